@@ rtl/core/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Invariant checked at every clock edge outside reset.
`define CSEM_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("invariant violated");

// Same-cycle implication checked outside reset.
`define CSEM_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication violated");

`endif

@@ rtl/core/csem_pkg.sv @@
`default_nettype none

package csem_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int COUNT_BITS  = 16;
    localparam int MAX_RESULTS = 16;
    localparam int CAPACITY    = (QUEUE_DEPTH < MAX_RESULTS) ? QUEUE_DEPTH : MAX_RESULTS;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int TOTAL_W     = $clog2(CAPACITY + 1);

    localparam int KIND_W   = 2;
    localparam int TID_W    = 8;
    localparam int AMT_W    = 16;
    localparam int STATUS_W = 3;
    localparam int SUM_W    = ((COUNT_BITS > AMT_W) ? COUNT_BITS : AMT_W) + 1;

    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_LVL_W = $clog2(CMDQ_DEPTH + 1);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    localparam logic [KIND_W-1:0] KIND_POST    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WAIT    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DESTROY = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CREATE  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_GRANTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_WOKEN    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_REJECTED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_QUEUED   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd5;
    localparam logic [STATUS_W-1:0] ST_DONE     = 3'd6;

    typedef enum logic [3:0] {
        OP_POST    = 4'b0001,
        OP_WAIT    = 4'b0010,
        OP_DESTROY = 4'b0100,
        OP_CREATE  = 4'b1000
    } t_op;

    typedef struct packed {
        t_op                    op;
        logic [TID_W-1:0]       tid;
        logic [AMT_W-1:0]       amount;
        logic [COUNT_BITS-1:0]  load_count;
    } t_cmd;

    typedef struct packed {
        logic               idle;
        logic               destroyed;
        logic [TOTAL_W-1:0] total;
    } t_back_stat;

endpackage

`default_nettype wire

@@ rtl/core/csem_if.sv @@
`default_nettype none

interface csem_in_if;
    import csem_pkg::*;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [TID_W-1:0]  thread_id;
    logic [AMT_W-1:0]  amount;
    modport source(output valid, kind, thread_id, amount, input ready);
    modport sink(input valid, kind, thread_id, amount, output ready);
endinterface

interface csem_out_if;
    import csem_pkg::*;
    logic                valid;
    logic                ready;
    logic [TID_W-1:0]    thread_id_out;
    logic [STATUS_W-1:0] status;
    logic                last;
    modport source(output valid, thread_id_out, status, last, input ready);
    modport sink(input valid, thread_id_out, status, last, output ready);
endinterface

`default_nettype wire

@@ rtl/core/csem_front.sv @@
`default_nettype none

module csem_front (
    input  wire              i_clk,
    input  wire              i_rst_n,
    csem_in_if.sink          i_req,
    output logic             o_push_valid,
    output csem_pkg::t_cmd   o_push_cmd,
    input  wire              i_push_ready
);
    import csem_pkg::*;

    logic r_valid, n_valid;
    t_cmd r_cmd, n_cmd;
    logic accept;

    assign i_req.ready  = !r_valid || i_push_ready;
    assign accept       = i_req.valid && i_req.ready;
    assign o_push_valid = r_valid;
    assign o_push_cmd   = r_cmd;

    always_comb begin
        n_cmd        = r_cmd;
        n_valid      = r_valid && !i_push_ready;
        if (accept) begin
            n_valid        = 1'b1;
            n_cmd.tid      = i_req.thread_id;
            n_cmd.amount   = i_req.amount;
            n_cmd.load_count = (SUM_W'(i_req.amount) > SUM_W'(COUNT_MAX)) ?
                               COUNT_MAX : COUNT_BITS'(i_req.amount);
            case (i_req.kind)
                KIND_POST:    n_cmd.op = OP_POST;
                KIND_WAIT:    n_cmd.op = OP_WAIT;
                KIND_DESTROY: n_cmd.op = OP_DESTROY;
                KIND_CREATE:  n_cmd.op = OP_CREATE;
                default:      n_cmd.op = OP_POST;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_cmd <= n_cmd;
    end

endmodule

`default_nettype wire

@@ rtl/core/csem_cmdq.sv @@
`default_nettype none

module csem_cmdq (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_push_valid,
    input  csem_pkg::t_cmd                      i_push_cmd,
    output logic                                o_push_ready,
    output logic                                o_pop_valid,
    output csem_pkg::t_cmd                      o_pop_cmd,
    input  wire                                 i_pop_ready,
    output logic [csem_pkg::CMDQ_LVL_W-1:0]     o_level
);
    import csem_pkg::*;

    t_cmd                  r_slot [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CMDQ_LVL_W-1:0] r_level;
    logic                  push, pop;

    function automatic logic [CMDQ_PTR_W-1:0] bump(input logic [CMDQ_PTR_W-1:0] p);
        return (p == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_push_ready = (r_level != CMDQ_LVL_W'(CMDQ_DEPTH));
    assign o_pop_valid  = (r_level != '0);
    assign o_pop_cmd    = r_slot[r_rd_ptr];
    assign o_level      = r_level;
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= bump(r_wr_ptr);
            end
            if (pop) begin
                r_rd_ptr <= bump(r_rd_ptr);
            end
            if (push && !pop) begin
                r_level <= r_level + 1'b1;
            end else if (pop && !push) begin
                r_level <= r_level - 1'b1;
            end
        end
        if (push) begin
            r_slot[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/csem_back.sv @@
`default_nettype none

module csem_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cmd_valid,
    input  csem_pkg::t_cmd       i_cmd,
    output logic                 o_cmd_ready,
    csem_out_if.source           o_rsp,
    output csem_pkg::t_back_stat o_stat
);
    import csem_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SINGLE = 4'b0010,
        S_FETCH  = 4'b0100,
        S_WAKE   = 4'b1000
    } t_state;

    t_state                r_state, n_state;
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic                  r_destroyed, n_destroyed;
    logic [PTR_W-1:0]      r_oldest, n_oldest;
    logic [PTR_W-1:0]      r_newest, n_newest;
    logic [TOTAL_W-1:0]    r_total, n_total;
    logic                  r_release, n_release;
    logic [TID_W-1:0]      r_res_tid, n_res_tid;
    logic [STATUS_W-1:0]   r_res_st, n_res_st;

    logic                  r_out_valid, n_out_valid;
    logic [TID_W-1:0]      r_out_tid, n_out_tid;
    logic [STATUS_W-1:0]   r_out_st, n_out_st;
    logic                  r_out_last, n_out_last;

    logic [TID_W-1:0]      r_mem [QUEUE_DEPTH];
    logic [TID_W-1:0]      r_rd_data;
    logic                  mem_we;

    logic                  can_load;
    logic                  more;
    logic                  is_last;
    logic [SUM_W-1:0]      sum;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_cmd_ready      = (r_state == S_IDLE);
    assign can_load         = !r_out_valid || o_rsp.ready;
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.thread_id_out = r_out_tid;
    assign o_rsp.status     = r_out_st;
    assign o_rsp.last       = r_out_last;
    assign o_stat.idle      = (r_state == S_IDLE);
    assign o_stat.destroyed = r_destroyed;
    assign o_stat.total     = r_total;

    assign sum     = SUM_W'(r_count) + SUM_W'(i_cmd.amount);
    assign more    = (r_total != '0) && (r_release || (r_count != '0));
    assign is_last = (r_total == TOTAL_W'(1)) ||
                     (!r_release && (r_count == COUNT_BITS'(1)));

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_destroyed = r_destroyed;
        n_oldest    = r_oldest;
        n_newest    = r_newest;
        n_total     = r_total;
        n_release   = r_release;
        n_res_tid   = r_res_tid;
        n_res_st    = r_res_st;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out_tid   = r_out_tid;
        n_out_st    = r_out_st;
        n_out_last  = r_out_last;
        mem_we      = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_state = S_SINGLE;
                    if (i_cmd.op == OP_CREATE) begin
                        n_count     = i_cmd.load_count;
                        n_destroyed = 1'b0;
                        n_oldest    = '0;
                        n_newest    = '0;
                        n_total     = '0;
                        n_res_tid   = '0;
                        n_res_st    = ST_DONE;
                    end else if (r_destroyed) begin
                        n_res_tid = i_cmd.tid;
                        n_res_st  = ST_REJECTED;
                    end else begin
                        case (i_cmd.op)
                            OP_POST: begin
                                n_count   = (sum > SUM_W'(COUNT_MAX)) ?
                                            COUNT_MAX : COUNT_BITS'(sum);
                                n_release = 1'b0;
                                n_state   = S_FETCH;
                            end
                            OP_WAIT: begin
                                n_res_tid = i_cmd.tid;
                                if (r_count != '0) begin
                                    n_count  = r_count - 1'b1;
                                    n_res_st = ST_GRANTED;
                                end else if (r_total >= TOTAL_W'(CAPACITY)) begin
                                    n_res_st = ST_FULL;
                                end else begin
                                    mem_we   = 1'b1;
                                    n_newest = next_slot(r_newest);
                                    n_total  = r_total + 1'b1;
                                    n_res_st = ST_QUEUED;
                                end
                            end
                            OP_DESTROY: begin
                                n_destroyed = 1'b1;
                                n_count     = '0;
                                n_release   = 1'b1;
                                n_state     = S_FETCH;
                            end
                            default: begin
                                n_state = S_IDLE;
                            end
                        endcase
                    end
                end
            end
            S_FETCH: begin
                if (more) begin
                    n_state = S_WAKE;
                end else begin
                    n_res_tid = '0;
                    n_res_st  = ST_DONE;
                    if (r_release) begin
                        n_oldest = '0;
                        n_newest = '0;
                    end
                    n_state = S_SINGLE;
                end
            end
            S_WAKE: begin
                if (can_load) begin
                    n_out_valid = 1'b1;
                    n_out_tid   = r_rd_data;
                    n_out_st    = r_release ? ST_RELEASED : ST_WOKEN;
                    n_out_last  = is_last;
                    n_oldest    = next_slot(r_oldest);
                    n_total     = r_total - 1'b1;
                    if (!r_release) begin
                        n_count = r_count - 1'b1;
                    end
                    if (is_last) begin
                        if (r_release) begin
                            n_oldest = '0;
                            n_newest = '0;
                            n_total  = '0;
                        end
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_FETCH;
                    end
                end
            end
            S_SINGLE: begin
                if (can_load) begin
                    n_out_valid = 1'b1;
                    n_out_tid   = r_res_tid;
                    n_out_st    = r_res_st;
                    n_out_last  = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_destroyed <= 1'b0;
            r_oldest    <= '0;
            r_newest    <= '0;
            r_total     <= '0;
            r_release   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_destroyed <= n_destroyed;
            r_oldest    <= n_oldest;
            r_newest    <= n_newest;
            r_total     <= n_total;
            r_release   <= n_release;
            r_out_valid <= n_out_valid;
        end
        r_res_tid  <= n_res_tid;
        r_res_st   <= n_res_st;
        r_out_tid  <= n_out_tid;
        r_out_st   <= n_out_st;
        r_out_last <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_newest] <= i_cmd.tid;
        end
        r_rd_data <= r_mem[r_oldest];
    end

endmodule

`default_nettype wire

@@ rtl/core/counting_semaphore_wait_queue.sv @@
`default_nettype none

// Counting semaphore with a FIFO of up to 16 waiting thread ids. Requests
// enter a decode register and a two-entry command queue, then a sequencer
// executes them one at a time against the unit count and the waiter memory.
// A create, wait or rejected request gives one result from the single
// state into the output register when the output is free; a post or
// destroy that releases no waiter gives its one result after a pass through
// the fetch state. A post or destroy that releases N waiters gives N
// results, one per pass through the fetch and wake states while the output
// is free, paced by the registered read of the waiter memory, with last set
// on the final one. Requests are accepted into the decode register and
// command queue while results drain. No clearing pass after reset.

module counting_semaphore_wait_queue (
    input  wire       i_clk,
    input  wire       i_rst_n,
    csem_in_if.sink   i_req,
    csem_out_if.source o_rsp
);
    import csem_pkg::*;

    `include "assert_macros.svh"

    logic                  push_valid, push_ready;
    t_cmd                  push_cmd;
    logic                  pop_valid, pop_ready;
    t_cmd                  pop_cmd;
    logic [CMDQ_LVL_W-1:0] q_level;
    t_back_stat            back_stat;

    csem_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .o_push_valid (push_valid),
        .o_push_cmd   (push_cmd),
        .i_push_ready (push_ready)
    );

    csem_cmdq u_cmdq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_cmd   (push_cmd),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_cmd    (pop_cmd),
        .i_pop_ready  (pop_ready),
        .o_level      (q_level)
    );

    csem_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (pop_valid),
        .i_cmd       (pop_cmd),
        .o_cmd_ready (pop_ready),
        .o_rsp       (o_rsp),
        .o_stat      (back_stat)
    );

    `CSEM_ASSERT_ALWAYS(a_total_cap, i_clk, i_rst_n, back_stat.total <= TOTAL_W'(CAPACITY))
    `CSEM_ASSERT_ALWAYS(a_q_level, i_clk, i_rst_n, q_level <= CMDQ_LVL_W'(CMDQ_DEPTH))
    `CSEM_ASSERT_IMPLY(a_destroy_empty, i_clk, i_rst_n, back_stat.destroyed && back_stat.idle, back_stat.total == '0)

endmodule

`default_nettype wire
